// ===== rtl/core/htb_pkg.sv =====
package htb_pkg;

    // Table geometry
    localparam int HOSTS  = 64;
    localparam int LEVELS = 7;
    localparam int ADDR_W = (HOSTS > 1) ? $clog2(HOSTS) : 1;
    localparam int LVL_W  = $clog2(LEVELS);

    // Fixed field widths
    localparam int IDX_W  = 6;
    localparam int TIME_W = 32;
    localparam int BO_W   = 10;
    localparam int TMO_W  = 15;

    // Front queue between classifier and executor
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Item function codes
    localparam logic FUNC_QUERY  = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_BACKOFF = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BACKOFF     = 2'd1;
    localparam logic [BO_W-1:0] RST_INITIAL_BACKOFF = 10'd23;
    localparam logic [BO_W-1:0] RST_MAX_BACKOFF     = 10'd600;

    // Result codes
    localparam logic [TMO_W-1:0] TMO_DEFAULT = 15'd10000;
    localparam logic [TMO_W-1:0] TMO_BLOCKED = 15'd1;
    localparam logic [TMO_W-1:0] TMO_NONE    = 15'd0;

    // Ladder levels for new entries, clamped to the top level
    localparam int LVL_TOP  = LEVELS - 1;
    localparam int LVL_OK   = (4 > LVL_TOP) ? LVL_TOP : 4;
    localparam int LVL_FAIL = (2 > LVL_TOP) ? LVL_TOP : 2;

    localparam logic [TMO_W-1:0] LADDER_MS [16] = '{
        15'd3000, 15'd6800, 15'd9000, 15'd10000, 15'd11600, 15'd14800, 15'd20000,
        15'd20000, 15'd20000, 15'd20000, 15'd20000, 15'd20000, 15'd20000,
        15'd20000, 15'd20000, 15'd20000
    };

    typedef struct packed {
        logic              func;
        logic              in_range;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] now_s;
        logic              outcome_ok;
    } item_t;

    typedef struct packed {
        logic [LVL_W-1:0]  level;
        logic [TIME_W-1:0] until_s;
        logic [BO_W-1:0]   interval;
        logic              was_blocked;
        logic              last_failed;
    } entry_t;

    typedef struct packed {
        logic [BO_W-1:0] initial_backoff_s;
        logic [BO_W-1:0] max_backoff_s;
    } cfg_t;

    typedef struct packed {
        logic avail;
        logic full;
    } qstat_t;

    function automatic logic [TMO_W-1:0] ladder_lookup(input logic [LVL_W-1:0] lvl);
        return LADDER_MS[4'(lvl)];
    endfunction

endpackage

// ===== rtl/core/htb_ram.sv =====
module htb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one word, read one word registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/htb_front.sv =====
module htb_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_func,
    input  logic [htb_pkg::IDX_W-1:0]    s_host_index,
    input  logic [htb_pkg::TIME_W-1:0]   s_now_s,
    input  logic                         s_outcome_ok,
    input  logic                         pop,
    output htb_pkg::item_t               head,
    output htb_pkg::qstat_t              qstat
);

    htb_pkg::item_t                  slot_reg [htb_pkg::QDEPTH];
    logic [htb_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [htb_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [htb_pkg::QCNT_W-1:0]      count_reg, count_next;
    htb_pkg::item_t                  item_in;
    logic                            push;

    // Classify the incoming item
    always_comb begin
        item_in.func       = s_func;
        item_in.in_range   = (32'(s_host_index) < 32'(htb_pkg::HOSTS));
        item_in.addr       = htb_pkg::ADDR_W'(s_host_index);
        item_in.now_s      = s_now_s;
        item_in.outcome_ok = s_outcome_ok;
    end

    assign qstat.full  = (count_reg == htb_pkg::QCNT_W'(htb_pkg::QDEPTH));
    assign qstat.avail = (count_reg != '0);
    assign s_ready     = !qstat.full;
    assign push        = s_valid && s_ready;
    assign head        = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == htb_pkg::QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == htb_pkg::QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued items
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== rtl/core/htb_back.sv =====
module htb_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  htb_pkg::cfg_t                cfg,
    input  htb_pkg::item_t               head,
    input  htb_pkg::qstat_t              qstat,
    output logic                         pop,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [htb_pkg::TMO_W-1:0]    m_timeout_ms,
    output logic                         m_blacklisted
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                          state_reg, state_next;
    htb_pkg::item_t                item_reg;
    logic                          entry_valid_reg [htb_pkg::HOSTS];
    logic                          m_valid_reg, m_valid_next;
    logic [htb_pkg::TMO_W-1:0]     tmo_reg;
    logic                          bl_reg;

    htb_pkg::entry_t               rd_entry;
    htb_pkg::entry_t               wr_entry;
    logic [$bits(htb_pkg::entry_t)-1:0] rd_bits;
    logic                          wr_en;
    logic                          set_valid;
    logic                          hit;
    logic                          blocked;
    logic [htb_pkg::TMO_W-1:0]     tmo_res;
    logic                          bl_res;
    logic [htb_pkg::BO_W:0]        doubled;
    logic                          exec;

    htb_ram #(
        .WIDTH ($bits(htb_pkg::entry_t)),
        .DEPTH (htb_pkg::HOSTS)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (item_reg.addr),
        .wdata (wr_entry),
        .raddr (head.addr),
        .rdata (rd_bits)
    );

    assign rd_entry = htb_pkg::entry_t'(rd_bits);
    assign exec     = (state_reg == ST_EXEC);
    assign pop      = (state_reg == ST_IDLE) && qstat.avail && (!m_valid_reg || m_ready);

    // Modify the entry read for the held item
    always_comb begin
        hit       = item_reg.in_range && entry_valid_reg[item_reg.addr];
        blocked   = rd_entry.until_s > item_reg.now_s;
        doubled   = {rd_entry.interval, 1'b0};
        wr_entry  = rd_entry;
        wr_en     = 1'b0;
        set_valid = 1'b0;
        tmo_res   = htb_pkg::TMO_NONE;
        bl_res    = 1'b0;
        if (item_reg.func == htb_pkg::FUNC_QUERY) begin
            if (!hit) begin
                tmo_res = htb_pkg::TMO_DEFAULT;
            end else if (blocked) begin
                wr_entry.was_blocked = 1'b1;
                wr_en   = exec;
                tmo_res = htb_pkg::TMO_BLOCKED;
                bl_res  = 1'b1;
            end else begin
                wr_entry.was_blocked = 1'b0;
                wr_en   = exec;
                tmo_res = htb_pkg::ladder_lookup(rd_entry.level);
            end
        end else if (item_reg.in_range) begin
            wr_en = exec;
            if (!hit) begin
                set_valid            = exec;
                wr_entry.until_s     = '0;
                wr_entry.interval    = cfg.initial_backoff_s;
                wr_entry.level       = item_reg.outcome_ok ?
                                       htb_pkg::LVL_W'(htb_pkg::LVL_OK) :
                                       htb_pkg::LVL_W'(htb_pkg::LVL_FAIL);
                wr_entry.was_blocked = 1'b0;
            end else if (item_reg.outcome_ok) begin
                if (rd_entry.level < htb_pkg::LVL_W'(htb_pkg::LVL_TOP)) begin
                    wr_entry.level = rd_entry.level + 1'b1;
                end
                wr_entry.until_s  = '0;
                wr_entry.interval = cfg.initial_backoff_s;
            end else if (!rd_entry.was_blocked) begin
                if (rd_entry.level != '0) begin
                    wr_entry.level = rd_entry.level - 1'b1;
                end
                if (rd_entry.last_failed) begin
                    wr_entry.until_s  = item_reg.now_s + htb_pkg::TIME_W'(rd_entry.interval);
                    wr_entry.interval = (doubled > {1'b0, cfg.max_backoff_s}) ?
                                        cfg.max_backoff_s :
                                        htb_pkg::BO_W'(doubled);
                end
            end
            wr_entry.last_failed = !item_reg.outcome_ok;
        end
    end

    // Sequence: read in idle, write back and post the result in exec
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                end
                if (pop) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Clear valid marks at reset, set on entry creation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < htb_pkg::HOSTS; i++) begin
                entry_valid_reg[i] <= 1'b0;
            end
        end else if (set_valid) begin
            entry_valid_reg[item_reg.addr] <= 1'b1;
        end
    end

    // Hold the item and the result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= head;
        end
        if (exec) begin
            tmo_reg <= tmo_res;
            bl_reg  <= bl_res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_timeout_ms  = tmo_reg;
    assign m_blacklisted = bl_reg;

endmodule

// ===== rtl/core/host_timeout_backoff_table_top.sv =====
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_func, s_host_index, s_now_s, s_outcome_ok
// m_        out        m_valid / m_ready    m_timeout_ms, m_blacklisted
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// The executor reads the host entry from the table RAM (registered read) in its idle
// state and, in its exec state, updates the entry and loads the result register.
// A two-deep queue in front accepts items while the executor or the result side stalls.
// Reset clears the per-host valid marks directly; no clearing pass is needed.
// The executor starts the next item only when the result register is free or is
// being taken in the same cycle.
module host_timeout_backoff_table_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_func,
    input  logic [htb_pkg::IDX_W-1:0]        s_host_index,
    input  logic [htb_pkg::TIME_W-1:0]       s_now_s,
    input  logic                             s_outcome_ok,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [htb_pkg::TMO_W-1:0]        m_timeout_ms,
    output logic                             m_blacklisted,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [htb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [htb_pkg::BO_W-1:0]         cfg_data
);

    htb_pkg::cfg_t    cfg_reg, cfg_next;
    htb_pkg::item_t   head;
    htb_pkg::qstat_t  qstat;
    logic             pop;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                htb_pkg::CFG_INITIAL_BACKOFF: cfg_next.initial_backoff_s = cfg_data;
                htb_pkg::CFG_MAX_BACKOFF:     cfg_next.max_backoff_s     = cfg_data;
                default:                      cfg_next                   = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.initial_backoff_s <= htb_pkg::RST_INITIAL_BACKOFF;
            cfg_reg.max_backoff_s     <= htb_pkg::RST_MAX_BACKOFF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    htb_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_host_index (s_host_index),
        .s_now_s      (s_now_s),
        .s_outcome_ok (s_outcome_ok),
        .pop          (pop),
        .head         (head),
        .qstat        (qstat)
    );

    htb_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .head          (head),
        .qstat         (qstat),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_timeout_ms  (m_timeout_ms),
        .m_blacklisted (m_blacklisted)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> qstat.avail)
        else $error("executor popped an empty queue");

    a_pop_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (!m_valid || m_ready))
        else $error("executor started while result register is held");

    a_blocked_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_blacklisted) |-> (m_timeout_ms == htb_pkg::TMO_BLOCKED))
        else $error("blacklisted result without blocked timeout");

    a_pop_no_back2back: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> !pop)
        else $error("executor popped while busy");
`endif

endmodule
